FILE: hw/rtl/tsl_pkg.sv
// Shared constants, register indexes and types for the sync byte locator.
// No dependencies; used by tsl_history, tsl_match and ts_sync_byte_locator.
package tsl_pkg;

    // Widths and limits
    localparam int unsigned MAX_PACKET_BYTES = 204;
    localparam int unsigned POS_BITS         = 24;
    localparam int unsigned HIST_ADDR_BITS   = 8;
    localparam int unsigned HIST_DEPTH       = 1 << HIST_ADDR_BITS;
    localparam int unsigned WORD_BITS        = 32;

    localparam logic [POS_BITS-1:0] POS_MAX   = {POS_BITS{1'b1}};
    localparam logic [7:0]          PSIZE_CAP = 8'(MAX_PACKET_BYTES);

    // Header patterns
    localparam logic [7:0]           SYNC_BYTE   = 8'h47;
    localparam logic [WORD_BITS-1:0] PACK_CODE   = 32'h0000_01BA;
    localparam logic [7:0]           PSIZE_RESET = 8'd188;

    // Configuration register indexes
    localparam logic REG_PACKET_SIZE  = 1'b0;
    localparam logic REG_PROGRAM_MODE = 1'b1;

    // Active configuration as seen by the datapath
    typedef struct packed {
        logic [7:0] psize;        // packet size, already capped
        logic       program_mode; // 1: pack header search
    } tsl_cfg_t;

endpackage

FILE: hw/rtl/tsl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module tsl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/tsl_history.sv
// Byte history: a four-byte window of the newest bytes plus a circular RAM of
// past windows, read one packet back. Depends on tsl_pkg and tsl_ram.
module tsl_history (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  logic [7:0]                          data_byte,
    input  tsl_pkg::tsl_cfg_t                   cfg,
    output logic [tsl_pkg::WORD_BITS-1:0]       cur_word,
    output logic [tsl_pkg::WORD_BITS-1:0]       old_word
);

    logic [tsl_pkg::WORD_BITS-1:0]      win_reg;
    logic [tsl_pkg::WORD_BITS-1:0]      win_next;
    logic [tsl_pkg::HIST_ADDR_BITS-1:0] wr_ptr_reg;
    logic [tsl_pkg::HIST_ADDR_BITS-1:0] wr_ptr_next;
    logic [tsl_pkg::HIST_ADDR_BITS-1:0] rd_addr;
    logic                               bypass_reg;
    logic                               bypass_next;
    logic [tsl_pkg::WORD_BITS-1:0]      ram_rd_data;

    // Newest byte enters at the low end of the window
    assign win_next    = {win_reg[tsl_pkg::WORD_BITS-9:0], data_byte};
    assign wr_ptr_next = wr_ptr_reg + 1'b1;
    // Window stored psize items ago; a size of zero means this item's own window
    assign rd_addr     = wr_ptr_reg - cfg.psize;
    assign bypass_next = (cfg.psize == 8'd0);

    // Window register, payload only
    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg    <= win_next;
            bypass_reg <= bypass_next;
        end
    end

    // Write pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
        end else if (accept) begin
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    tsl_ram #(
        .WIDTH (tsl_pkg::WORD_BITS),
        .DEPTH (tsl_pkg::HIST_DEPTH)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (wr_ptr_reg),
        .wr_data (win_next),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    assign cur_word = win_reg;
    assign old_word = bypass_reg ? win_reg : ram_rd_data;

endmodule

FILE: hw/rtl/tsl_match.sv
// Header compare and buffer position tracking for the item in the input stage.
// Depends on tsl_pkg.
module tsl_match (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          buffer_end,
    input  tsl_pkg::tsl_cfg_t             cfg,
    input  logic [tsl_pkg::WORD_BITS-1:0] cur_word,
    input  logic [tsl_pkg::WORD_BITS-1:0] old_word,
    output logic                          hit,
    output logic [tsl_pkg::POS_BITS-1:0]  position
);

    logic [tsl_pkg::POS_BITS-1:0] pos_reg;
    logic [tsl_pkg::POS_BITS-1:0] pos_next;
    logic [tsl_pkg::POS_BITS-1:0] start_reg;
    logic [tsl_pkg::POS_BITS-1:0] start_next;
    logic [8:0]                   back;
    logic [tsl_pkg::POS_BITS-1:0] cand;
    logic [tsl_pkg::POS_BITS:0]   resume_sum;
    logic                         can_test;
    logic                         pattern_ok;
    logic                         ts_old_ok;
    logic                         ts_cur_ok;

    // Distance from the newest byte back to the candidate start
    assign back = {1'b0, cfg.psize} + (cfg.program_mode ? 9'd3 : 9'd1);
    assign cand = pos_reg - tsl_pkg::POS_BITS'(back);

    assign can_test = (pos_reg != tsl_pkg::POS_MAX)
                   && (pos_reg >= tsl_pkg::POS_BITS'(back))
                   && (cand >= start_reg);

    // Sync byte followed by a clear error bit, at both headers
    assign ts_old_ok = (old_word[15:8] == tsl_pkg::SYNC_BYTE) && !old_word[7];
    assign ts_cur_ok = (cur_word[15:8] == tsl_pkg::SYNC_BYTE) && !cur_word[7];

    assign pattern_ok = cfg.program_mode
        ? ((old_word == tsl_pkg::PACK_CODE) && (cur_word == tsl_pkg::PACK_CODE))
        : (ts_old_ok && ts_cur_ok);

    assign hit      = can_test && pattern_ok;
    assign position = hit ? cand : '0;

    // Next search start, saturating
    assign resume_sum = {1'b0, cand} + {{(tsl_pkg::POS_BITS-7){1'b0}}, cfg.psize};

    always_comb begin
        start_next = start_reg;
        pos_next   = pos_reg;
        if (hit) begin
            start_next = resume_sum[tsl_pkg::POS_BITS] ? tsl_pkg::POS_MAX
                                                       : resume_sum[tsl_pkg::POS_BITS-1:0];
        end
        if (pos_reg != tsl_pkg::POS_MAX) begin
            pos_next = pos_reg + 1'b1;
        end
        if (buffer_end) begin
            pos_next   = '0;
            start_next = '0;
        end
    end

    // Position state moves with the item leaving the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            start_reg <= '0;
        end else if (advance) begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
        end
    end

endmodule

FILE: hw/rtl/ts_sync_byte_locator.sv
// Sync byte locator top level: config registers, handshake and result register.
// An item passes the input stage, then the result register, before m_valid.
// Throughput: one item per cycle unless m_ready stalls; input stage and result
// register decouple the channels; per item, one history RAM write and one read.
// Reset: control, position and config registers clear synchronously; the
// history RAM is not cleared and needs no clearing pass.
module ts_sync_byte_locator (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration write port
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [7:0]                   cfg_wr_data,
    // Input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_data_byte,
    input  logic                         s_buffer_end,
    // Result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_sync_hit,
    output logic [tsl_pkg::POS_BITS-1:0] m_sync_position
);

    logic [7:0]                    psize_reg;
    logic                          program_reg;
    tsl_pkg::tsl_cfg_t             cfg;
    logic                          s_accept;
    logic                          advance;
    logic                          a_vld_reg;
    logic                          a_end_reg;
    logic                          m_valid_reg;
    logic                          m_hit_reg;
    logic [tsl_pkg::POS_BITS-1:0]  m_pos_reg;
    logic [tsl_pkg::WORD_BITS-1:0] cur_word;
    logic [tsl_pkg::WORD_BITS-1:0] old_word;
    logic                          hit;
    logic [tsl_pkg::POS_BITS-1:0]  position;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            psize_reg   <= tsl_pkg::PSIZE_RESET;
            program_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tsl_pkg::REG_PACKET_SIZE:  psize_reg   <= cfg_wr_data;
                tsl_pkg::REG_PROGRAM_MODE: program_reg <= cfg_wr_data[0];
            endcase
        end
    end

    assign cfg.psize        = (psize_reg > tsl_pkg::PSIZE_CAP) ? tsl_pkg::PSIZE_CAP : psize_reg;
    assign cfg.program_mode = program_reg;

    // Handshake: input stage drains into the result register
    assign advance  = a_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !a_vld_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                a_vld_reg <= 1'b1;
            end else if (advance) begin
                a_vld_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Input stage payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_end_reg <= s_buffer_end;
        end
    end

    tsl_history u_history (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .data_byte (s_data_byte),
        .cfg       (cfg),
        .cur_word  (cur_word),
        .old_word  (old_word)
    );

    tsl_match u_match (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .buffer_end (a_end_reg),
        .cfg        (cfg),
        .cur_word   (cur_word),
        .old_word   (old_word),
        .hit        (hit),
        .position   (position)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_hit_reg <= hit;
            m_pos_reg <= position;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sync_hit      = m_hit_reg;
    assign m_sync_position = m_pos_reg;

`ifndef SYNTH
    // An empty input stage always takes an item
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !a_vld_reg |-> s_ready)
        else $error("input stage empty but not ready");

    // A miss reports position zero
    a_miss_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_sync_hit) |-> (m_sync_position == '0))
        else $error("nonzero position on a miss");

    // A hit never lies at the saturated position
    a_hit_not_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_sync_hit) |-> (m_sync_position != tsl_pkg::POS_MAX))
        else $error("hit at saturated position");

    // Every item leaving the input stage shows up as a result next cycle
    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("result lost after input stage");
`endif

endmodule
